>>> hw/rtl/wrr_pkg.sv
// ----------------------------------------------------------------------------
// wrr_pkg
// Shared types and constants of the weighted round-robin scheduler.
// ----------------------------------------------------------------------------
package wrr_pkg;

  localparam int unsigned KIND_W      = 2;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned ACTIVE_W    = 3;
  localparam int unsigned WEIGHT_W    = 8;
  localparam int unsigned CREDIT_W    = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned WEIGHT_REGS = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT0 = 3'd1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQUEUE  = 2'd0,
    KIND_DEQUEUE  = 2'd1,
    KIND_CLEAR    = 2'd2,
    KIND_RESERVED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_WRAP
  } state_e;

endpackage

>>> hw/rtl/wrr_wrap_unit.sv
// ----------------------------------------------------------------------------
// wrr_wrap_unit
// Shared compare and subtract step that wraps the queue pointer into the
// rotation.
// ----------------------------------------------------------------------------
module wrr_wrap_unit #(
  parameter int unsigned CW = 4
) (
  input  logic [CW-1:0] val_i,
  input  logic [CW-1:0] n_i,
  output logic [CW-1:0] red_o,
  output logic          in_range_o
);

  always_comb begin
    if (val_i >= n_i) begin
      red_o = val_i - n_i;
    end else begin
      red_o = val_i;
    end
    in_range_o = (red_o < n_i);
  end

endmodule

>>> hw/rtl/weighted_round_robin_scheduler.sv
// Enqueue, clear and reserved kinds: taken in the cycle of the transfer.
// Dequeue: a credit update step, then a scan step per queue visited (up to active
//   count plus one) and a wrap step per further subtraction when the pointer lies
//   outside the rotation; result registered.
// Input stalls until the result register loads; a stalled result holds the last scan.
// Reset: counts, credits and pointer zero, weights one, active count four.
// ----------------------------------------------------------------------------
// weighted_round_robin_scheduler
// Weighted round-robin packet scheduler with saturating per-queue counts.
// ----------------------------------------------------------------------------
module weighted_round_robin_scheduler #(
  parameter int unsigned QUEUES     = 4,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wrr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wrr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [wrr_pkg::KIND_W-1:0]       kind_i,
  input  logic [wrr_pkg::IDX_W-1:0]        queue_index_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             found_o,
  output logic [wrr_pkg::IDX_W-1:0]        granted_queue_o
);

  localparam int unsigned QW    = $clog2(QUEUES);
  localparam int unsigned CW    = QW + 2;
  localparam int unsigned CFG_Q = (QUEUES < wrr_pkg::WEIGHT_REGS) ? QUEUES
                                                                  : wrr_pkg::WEIGHT_REGS;
  localparam logic [CW-1:0] QUEUES_C = CW'(QUEUES);

  wrr_pkg::state_e state_q, state_d;

  logic [wrr_pkg::ACTIVE_W-1:0] active_q;
  logic [wrr_pkg::WEIGHT_W-1:0] weight_q [QUEUES];
  logic [COUNT_BITS-1:0]        count_q  [QUEUES];
  logic [COUNT_BITS-1:0]        count_d  [QUEUES];
  logic [wrr_pkg::CREDIT_W-1:0] credit_q [QUEUES];
  logic [wrr_pkg::CREDIT_W-1:0] credit_d [QUEUES];
  logic [QW-1:0]                cur_q, cur_d;
  logic [CW-1:0]                n_q, n_d;
  logic [CW-1:0]                i_q, i_d;
  logic [CW-1:0]                p_q, p_d;

  logic                         out_valid_q;
  logic                         found_q;
  logic [wrr_pkg::IDX_W-1:0]    granted_q;
  logic                         out_load;
  logic                         out_found;
  logic                         out_free;

  logic [CW-1:0]                act_n;
  logic [CW-1:0]                active_ext;
  logic [CW-1:0]                mod_val;
  logic [CW-1:0]                mod_red;
  logic                         mod_in_range;
  logic                         adv;
  logic [QW-1:0]                enq_idx;
  logic                         enq_ok;
  logic [QW-1:0]                nxt_idx;
  logic [wrr_pkg::WEIGHT_W-1:0] nxt_weight;

  // active count clamped to the queues present, zero taken as one
  assign active_ext = CW'(active_q);
  always_comb begin
    if (active_ext == '0) begin
      act_n = CW'(1);
    end else if (active_ext > QUEUES_C) begin
      act_n = QUEUES_C;
    end else begin
      act_n = active_ext;
    end
  end

  assign mod_val = (state_q == wrr_pkg::ST_WRAP) ? p_q : CW'(cur_q) + CW'(1);

  wrr_wrap_unit #(
    .CW (CW)
  ) u_wrap (
    .val_i      (mod_val),
    .n_i        (n_q),
    .red_o      (mod_red),
    .in_range_o (mod_in_range)
  );

  assign enq_idx    = QW'(queue_index_i);
  assign enq_ok     = (CW'(queue_index_i) < QUEUES_C);
  assign nxt_idx    = mod_red[QW-1:0];
  assign nxt_weight = weight_q[nxt_idx];
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    n_d       = n_q;
    i_d       = i_q;
    p_d       = p_q;
    credit_d  = credit_q;
    count_d   = count_q;
    out_load  = 1'b0;
    out_found = 1'b0;
    adv       = 1'b0;

    case (state_q)
      wrr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (wrr_pkg::kind_e'(kind_i))
            wrr_pkg::KIND_ENQUEUE: begin
              if (enq_ok && (count_q[enq_idx] != '1)) begin
                count_d[enq_idx] = count_q[enq_idx] + COUNT_BITS'(1);
              end
            end
            wrr_pkg::KIND_DEQUEUE: begin
              n_d     = act_n;
              state_d = wrr_pkg::ST_START;
            end
            wrr_pkg::KIND_CLEAR: begin
              for (int k = 0; k < QUEUES; k++) begin
                credit_d[k] = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      wrr_pkg::ST_START: begin
        i_d     = '0;
        state_d = wrr_pkg::ST_SCAN;
        if (credit_q[cur_q] == '0) begin
          adv = 1'b1;
        end else begin
          credit_d[cur_q] = credit_q[cur_q] - wrr_pkg::CREDIT_W'(1);
        end
      end
      wrr_pkg::ST_SCAN: begin
        if (i_q == n_q) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = wrr_pkg::ST_IDLE;
          end
        end else if (count_q[cur_q] != '0) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_found      = 1'b1;
            count_d[cur_q] = count_q[cur_q] - COUNT_BITS'(1);
            state_d        = wrr_pkg::ST_IDLE;
          end
        end else begin
          credit_d[cur_q] = '0;
          i_d             = i_q + CW'(1);
          adv             = 1'b1;
        end
      end
      wrr_pkg::ST_WRAP: begin
        adv = 1'b1;
      end
      default: begin
        state_d = wrr_pkg::ST_IDLE;
      end
    endcase

    // pointer advance through the shared wrap unit, then credit reload once the pointer is in range
    if (adv) begin
      if (mod_in_range) begin
        cur_d   = nxt_idx;
        state_d = wrr_pkg::ST_SCAN;
        if (nxt_weight == '0) begin
          credit_d[nxt_idx] = '0;
        end else begin
          credit_d[nxt_idx] = nxt_weight - wrr_pkg::WEIGHT_W'(1);
        end
      end else begin
        p_d     = mod_red;
        state_d = wrr_pkg::ST_WRAP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wrr_pkg::ST_IDLE;
      cur_q       <= '0;
      n_q         <= CW'(1);
      i_q         <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < QUEUES; k++) begin
        count_q[k]  <= '0;
        credit_q[k] <= '0;
      end
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      n_q      <= n_d;
      i_q      <= i_d;
      p_q      <= p_d;
      count_q  <= count_d;
      credit_q <= credit_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      found_q <= out_found;
      if (out_found) begin
        granted_q <= wrr_pkg::IDX_W'(cur_q);
      end else begin
        granted_q <= '0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= wrr_pkg::ACTIVE_RESET;
      for (int k = 0; k < QUEUES; k++) begin
        weight_q[k] <= wrr_pkg::WEIGHT_RESET;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == wrr_pkg::CFG_ACTIVE) begin
        active_q <= cfg_wdata_i[wrr_pkg::ACTIVE_W-1:0];
      end
      for (int k = 0; k < CFG_Q; k++) begin
        if (cfg_index_i == wrr_pkg::CFG_WEIGHT0 + wrr_pkg::CFG_IDX_W'(k)) begin
          weight_q[k] <= cfg_wdata_i;
        end
      end
    end
  end

  assign in_stall_o      = (state_q != wrr_pkg::ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign granted_queue_o = granted_q;

endmodule
